// File: rtl/ptu_pkg.sv
// shared types, constants and helpers for the page translation unit
package ptu_pkg;

  localparam int TABLE_PAGE_BITS = 10;
  localparam int TABLE_ENTRIES   = 1 << TABLE_PAGE_BITS;
  localparam int PAGE_SIZE       = 4096;
  localparam int PAGE_BITS       = $clog2(PAGE_SIZE);
  localparam int ADDR_W          = 32;
  localparam int VPN_W           = ADDR_W - PAGE_BITS;
  localparam int SIZE_W          = 13;
  localparam int PFE_W           = 3;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [VPN_W:0]      TABLE_SIZE      = (VPN_W + 1)'(1) << TABLE_PAGE_BITS;
  localparam logic [ADDR_W-1:0]   RAM_BYTES_RESET = 32'd16777216;

  localparam logic [PFE_W-1:0] PFE_NONE       = 3'h0;
  localparam logic [PFE_W-1:0] PFE_USER       = 3'h4;
  localparam logic [PFE_W-1:0] PFE_WRITE_PROT = 3'h3;
  localparam logic [PFE_W-1:0] PFE_USER_PROT  = 3'h5;

  typedef enum logic [1:0] {
    KIND_TRANSLATE,
    KIND_MAP,
    KIND_INVALIDATE,
    KIND_FLUSH
  } kind_t;

  typedef enum logic [2:0] {
    FAULT_NONE,
    FAULT_ZERO_SIZE,
    FAULT_CROSS_PAGE,
    FAULT_NOT_PRESENT,
    FAULT_READ_ONLY,
    FAULT_SUPERVISOR,
    FAULT_BAD_PHYS,
    FAULT_BEYOND_TABLE
  } fault_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAGING_ON,
    CFG_RAM_BYTES
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             dirty;
    logic             accessed;
    logic             user;
    logic             writable;
    logic             present;
    logic [VPN_W-1:0] frame;
  } pte_t;

  typedef struct packed {
    logic              paging_on;
    logic [ADDR_W-1:0] ram_bytes;
  } cfg_t;

  typedef struct packed {
    logic                       rd_en;
    logic [TABLE_PAGE_BITS-1:0] rd_addr;
    logic                       wr_en;
    logic [TABLE_PAGE_BITS-1:0] wr_addr;
  } mem_ctl_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] lin_addr;
    logic [SIZE_W-1:0] access_bytes;
    logic              is_write;
    logic              is_user;
    logic [VPN_W-1:0]  map_page_index;
    logic [VPN_W-1:0]  map_frame;
    logic              map_writable;
    logic              map_user_ok;
    logic              map_present;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] physical_address;
    fault_t            fault_code;
    logic [PFE_W-1:0]  page_fault_error;
    logic              page_accessed;
    logic              page_dirty;
  } result_t;

  function automatic logic phys_bad(logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size,
                                    logic [ADDR_W-1:0] ram);
    logic [ADDR_W-1:0] room;
    room = ram - addr;
    return (size == '0) || (addr > ram) || ({{(ADDR_W - SIZE_W){1'b0}}, size} > room);
  endfunction

  function automatic logic beyond_table(logic [VPN_W-1:0] vpn);
    return {1'b0, vpn} >= TABLE_SIZE;
  endfunction

endpackage

// File: rtl/ptu_ifs.sv
// valid/ready channel interfaces for items, results and configuration writes
interface ptu_in_if;
  import ptu_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] lin_addr;
  logic [SIZE_W-1:0] access_bytes;
  logic              is_write;
  logic              is_user;
  logic [VPN_W-1:0]  map_page_index;
  logic [VPN_W-1:0]  map_frame;
  logic              map_writable;
  logic              map_user_ok;
  logic              map_present;

  modport source (output valid, kind, lin_addr, access_bytes, is_write, is_user,
                  map_page_index, map_frame, map_writable, map_user_ok, map_present,
                  input ready);
  modport sink (input valid, kind, lin_addr, access_bytes, is_write, is_user,
                map_page_index, map_frame, map_writable, map_user_ok, map_present,
                output ready);
endinterface

interface ptu_out_if;
  import ptu_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] physical_address;
  logic [2:0]        fault_code;
  logic [PFE_W-1:0]  page_fault_error;
  logic              page_accessed;
  logic              page_dirty;

  modport source (output valid, physical_address, fault_code, page_fault_error,
                  page_accessed, page_dirty, input ready);
  modport sink (input valid, physical_address, fault_code, page_fault_error,
                page_accessed, page_dirty, output ready);
endinterface

interface ptu_cfg_if;
  import ptu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/ptu_ram.sv
// one-write one-read synchronous ram with registered read data
module ptu_ram #(
  parameter int WIDTH = 1
) (
  input  logic              clk,
  input  ptu_pkg::mem_ctl_t ctl,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);
  import ptu_pkg::*;

  logic [WIDTH-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[ctl.rd_addr];
    end
  end

endmodule

// File: rtl/ptu_ctrl.sv
// sequencer and read-modify-write datapath over the page and cached-bit memories
module ptu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  ptu_in_if.sink            in_item,
  ptu_out_if.source         out_item,
  input  ptu_pkg::cfg_t     cfg,
  output ptu_pkg::mem_ctl_t pte_ctl,
  output ptu_pkg::pte_t     pte_wdata,
  input  ptu_pkg::pte_t     pte_rdata,
  output ptu_pkg::mem_ctl_t cch_ctl,
  output logic              cch_wdata,
  input  logic              cch_rdata
);
  import ptu_pkg::*;

  state_t                     state_r, state_nxt;
  logic [TABLE_PAGE_BITS-1:0] sweep_r, sweep_nxt;
  item_t                      item_r, item_nxt;
  logic                       out_valid_r, out_valid_nxt;
  result_t                    res_r, res_nxt;

  logic                       in_accept;
  logic [VPN_W-1:0]           in_vpn;
  logic                       sweep_last;
  logic                       out_free;
  logic                       exec_go;

  // exec datapath
  result_t                    res_calc;
  pte_t                       pte_upd;
  logic                       pte_we;
  logic                       cch_we;
  logic                       cch_wval;
  logic [TABLE_PAGE_BITS-1:0] exec_addr;
  logic [VPN_W-1:0]           vpn;
  logic                       lin_beyond;
  logic [ADDR_W-1:0]          last_byte;
  logic [ADDR_W-1:0]          phys;

  assign in_accept  = in_item.valid && in_item.ready;
  assign in_vpn     = (kind_t'(in_item.kind) == KIND_MAP) ? in_item.map_page_index
                                                          : in_item.lin_addr[ADDR_W-1:PAGE_BITS];
  assign sweep_last = &sweep_r;
  assign out_free   = !out_valid_r || out_item.ready;
  assign exec_go    = (state_r == ST_EXEC) && out_free;

  always_comb begin
    vpn        = item_r.lin_addr[ADDR_W-1:PAGE_BITS];
    lin_beyond = beyond_table(vpn);
    last_byte  = item_r.lin_addr + ADDR_W'(item_r.access_bytes) - ADDR_W'(1);
    phys       = {pte_rdata.frame, item_r.lin_addr[PAGE_BITS-1:0]};
    pte_upd    = pte_rdata;
    pte_we     = 1'b0;
    cch_we     = 1'b0;
    cch_wval   = 1'b0;
    exec_addr  = vpn[TABLE_PAGE_BITS-1:0];
    res_calc.physical_address = '0;
    res_calc.fault_code       = FAULT_NONE;
    res_calc.page_fault_error = PFE_NONE;
    case (item_r.kind)
      KIND_TRANSLATE: begin
        if (!cfg.paging_on) begin
          if (phys_bad(item_r.lin_addr, item_r.access_bytes, cfg.ram_bytes)) begin
            res_calc.fault_code = FAULT_BAD_PHYS;
          end else begin
            res_calc.physical_address = item_r.lin_addr;
          end
        end else if (item_r.access_bytes == '0) begin
          res_calc.fault_code = FAULT_ZERO_SIZE;
        end else if (last_byte[ADDR_W-1:PAGE_BITS] != vpn) begin
          res_calc.fault_code = FAULT_CROSS_PAGE;
        end else if (lin_beyond) begin
          res_calc.fault_code       = FAULT_BEYOND_TABLE;
          res_calc.page_fault_error = item_r.is_user ? PFE_USER : PFE_NONE;
        end else if (!cch_rdata && !pte_rdata.present) begin
          res_calc.fault_code       = FAULT_NOT_PRESENT;
          res_calc.page_fault_error = item_r.is_user ? PFE_USER : PFE_NONE;
        end else if (item_r.is_write && !pte_rdata.writable) begin
          res_calc.fault_code       = FAULT_READ_ONLY;
          res_calc.page_fault_error = PFE_WRITE_PROT | (item_r.is_user ? PFE_USER : PFE_NONE);
        end else if (item_r.is_user && !pte_rdata.user) begin
          res_calc.fault_code       = FAULT_SUPERVISOR;
          res_calc.page_fault_error = PFE_USER_PROT;
        end else begin
          if (!cch_rdata) begin
            pte_upd.accessed = 1'b1;
            if (item_r.is_write) begin
              pte_upd.dirty = 1'b1;
            end
            pte_we   = 1'b1;
            cch_we   = 1'b1;
            cch_wval = 1'b1;
          end
          if (phys_bad(phys, item_r.access_bytes, cfg.ram_bytes)) begin
            res_calc.fault_code = FAULT_BAD_PHYS;
          end else begin
            res_calc.physical_address = phys;
          end
        end
      end
      KIND_MAP: begin
        exec_addr        = item_r.map_page_index[TABLE_PAGE_BITS-1:0];
        pte_upd.dirty    = 1'b0;
        pte_upd.accessed = 1'b0;
        pte_upd.user     = item_r.map_user_ok;
        pte_upd.writable = item_r.map_writable;
        pte_upd.present  = item_r.map_present;
        pte_upd.frame    = item_r.map_frame;
        pte_we           = !beyond_table(item_r.map_page_index);
        cch_we           = pte_we;
      end
      KIND_INVALIDATE: begin
        cch_we = !lin_beyond;
      end
      default: begin
      end
    endcase
    // map results always report cleared bits, so the linear page test is enough
    res_calc.page_accessed = !lin_beyond && pte_upd.accessed;
    res_calc.page_dirty    = !lin_beyond && pte_upd.dirty;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = (item_r.kind == KIND_FLUSH) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    in_item.ready   = (state_r == ST_IDLE);
    pte_ctl.rd_en   = in_accept;
    pte_ctl.rd_addr = in_vpn[TABLE_PAGE_BITS-1:0];
    pte_ctl.wr_en   = 1'b0;
    pte_ctl.wr_addr = exec_addr;
    pte_wdata       = pte_upd;
    cch_ctl.rd_en   = in_accept;
    cch_ctl.rd_addr = in_vpn[TABLE_PAGE_BITS-1:0];
    cch_ctl.wr_en   = 1'b0;
    cch_ctl.wr_addr = exec_addr;
    cch_wdata       = cch_wval;
    sweep_nxt       = sweep_r;
    case (state_r)
      ST_INIT: begin
        pte_ctl.wr_en   = 1'b1;
        pte_ctl.wr_addr = sweep_r;
        pte_wdata       = '0;
        cch_ctl.wr_en   = 1'b1;
        cch_ctl.wr_addr = sweep_r;
        cch_wdata       = 1'b0;
        sweep_nxt       = sweep_r + TABLE_PAGE_BITS'(1);
      end
      ST_EXEC: begin
        pte_ctl.wr_en = exec_go && pte_we;
        cch_ctl.wr_en = exec_go && cch_we;
      end
      ST_FLUSH: begin
        cch_ctl.wr_en   = 1'b1;
        cch_ctl.wr_addr = sweep_r;
        cch_wdata       = 1'b0;
        sweep_nxt       = sweep_r + TABLE_PAGE_BITS'(1);
      end
      default: begin
      end
    endcase

    item_nxt = item_r;
    if (in_accept) begin
      item_nxt.kind           = kind_t'(in_item.kind);
      item_nxt.lin_addr       = in_item.lin_addr;
      item_nxt.access_bytes   = in_item.access_bytes;
      item_nxt.is_write       = in_item.is_write;
      item_nxt.is_user        = in_item.is_user;
      item_nxt.map_page_index = in_item.map_page_index;
      item_nxt.map_frame      = in_item.map_frame;
      item_nxt.map_writable   = in_item.map_writable;
      item_nxt.map_user_ok    = in_item.map_user_ok;
      item_nxt.map_present    = in_item.map_present;
    end

    res_nxt       = exec_go ? res_calc : res_r;
    out_valid_nxt = exec_go ? 1'b1 : (out_valid_r && !out_item.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_item.valid            = out_valid_r;
  assign out_item.physical_address = res_r.physical_address;
  assign out_item.fault_code       = res_r.fault_code;
  assign out_item.page_fault_error = res_r.page_fault_error;
  assign out_item.page_accessed    = res_r.page_accessed;
  assign out_item.page_dirty       = res_r.page_dirty;

endmodule

// File: rtl/page_translation_unit.sv
// page translation unit top level: configuration registers, memories and sequencer
// per item: page memory read, then update and result register, waiting for a free output
// one item in flight: the next waits for the read then write-back of the page memory
// a flush adds a sweep of all 1024 cached-bit memory entries before the next item transfer
// reset: a clearing pass over all 1024 entries of both memories, input ready low meanwhile
// configuration writes are always ready, paging_on resets to 0 and ram_bytes to 16777216
module page_translation_unit (
  input  logic      clk,
  input  logic      rst_n,
  ptu_in_if.sink    in_item,
  ptu_out_if.source out_item,
  ptu_cfg_if.sink   cfg_wr
);
  import ptu_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  mem_ctl_t pte_ctl;
  pte_t     pte_wdata;
  pte_t     pte_rdata;
  mem_ctl_t cch_ctl;
  logic     cch_wdata;
  logic     cch_rdata;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_index_t'(cfg_wr.index))
        CFG_PAGING_ON: cfg_nxt.paging_on = cfg_wr.data[0];
        CFG_RAM_BYTES: cfg_nxt.ram_bytes = cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paging_on <= 1'b0;
      cfg_r.ram_bytes <= RAM_BYTES_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ptu_ram #(.WIDTH($bits(pte_t))) u_pte_ram (
    .clk   (clk),
    .ctl   (pte_ctl),
    .wdata (pte_wdata),
    .rdata (pte_rdata)
  );

  ptu_ram #(.WIDTH(1)) u_cch_ram (
    .clk   (clk),
    .ctl   (cch_ctl),
    .wdata (cch_wdata),
    .rdata (cch_rdata)
  );

  ptu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg       (cfg_r),
    .pte_ctl   (pte_ctl),
    .pte_wdata (pte_wdata),
    .pte_rdata (pte_rdata),
    .cch_ctl   (cch_ctl),
    .cch_wdata (cch_wdata),
    .cch_rdata (cch_rdata)
  );

endmodule

// File: rtl/ptu_checker.sv
// port-level assertions for the page translation unit and their bind
module ptu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_fault_code,
  input logic [2:0] out_pfe
);
  import ptu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_pfe_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault_code == FAULT_NONE || out_fault_code == FAULT_ZERO_SIZE ||
                  out_fault_code == FAULT_CROSS_PAGE || out_fault_code == FAULT_BAD_PHYS)
    |-> out_pfe == PFE_NONE)
    else $error("page fault error code set for a non page fault");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block not held off after reset");

endmodule

bind page_translation_unit ptu_checker u_ptu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .out_fault_code (out_item.fault_code),
  .out_pfe        (out_item.page_fault_error)
);
